// ----- rtl/fwps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fwps_pkg
// Types and constants shared by the flash word program sequencer modules.
// ----------------------------------------------------------------------------
package fwps_pkg;

    localparam int OFF_W     = 19;
    localparam int DATA_W    = 32;
    localparam int HOLD_W    = 16;
    localparam int WAIT_W    = 17;
    localparam int CFG_IDX_W = 3;

    // flash command register bits
    localparam logic [DATA_W-1:0] BIT_CE    = 32'h0000_0040;
    localparam logic [DATA_W-1:0] BIT_WE    = 32'h0000_0080;
    localparam int                NVR_POS   = 9;
    localparam logic [DATA_W-1:0] BIT_PROG  = 32'h0000_1000;
    localparam logic [DATA_W-1:0] BIT_PROG2 = 32'h0000_2000;

    // high address bit for odd words, main block and information block
    localparam int ADDR_HI_MAIN_POS = 18;
    localparam int ADDR_HI_NVR_POS  = 13;

    localparam logic [WAIT_W-1:0] CLOSE_HOLD_US = 17'd1;

    // target register codes
    localparam logic [1:0] TGT_CMD  = 2'd0;
    localparam logic [1:0] TGT_ADDR = 2'd1;
    localparam logic [1:0] TGT_DIN  = 2'd2;
    localparam logic [1:0] TGT_CTRL = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_COMMAND     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP_WAIT_US    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_SETUP_US = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_SETUP_US = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_PULSE_US = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_HOLD_US  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_HOLD_US  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_US      = 3'd7;

    // configuration reset values
    localparam logic [DATA_W-1:0] RST_BASE_COMMAND     = 32'd0;
    localparam logic [HOLD_W-1:0] RST_SETUP_WAIT_US    = 16'd22;
    localparam logic [HOLD_W-1:0] RST_PROGRAM_SETUP_US = 16'd54;
    localparam logic [HOLD_W-1:0] RST_ADDRESS_SETUP_US = 16'd1;
    localparam logic [HOLD_W-1:0] RST_PROGRAM_PULSE_US = 16'd5;
    localparam logic [HOLD_W-1:0] RST_ADDRESS_HOLD_US  = 16'd1;
    localparam logic [HOLD_W-1:0] RST_PROGRAM_HOLD_US  = 16'd1;
    localparam logic [HOLD_W-1:0] RST_RECOVERY_US      = 16'd54;

    typedef struct packed {
        logic [DATA_W-1:0] base_command;
        logic [HOLD_W-1:0] setup_wait_us;
        logic [HOLD_W-1:0] program_setup_us;
        logic [HOLD_W-1:0] address_setup_us;
        logic [HOLD_W-1:0] program_pulse_us;
        logic [HOLD_W-1:0] address_hold_us;
        logic [HOLD_W-1:0] program_hold_us;
        logic [HOLD_W-1:0] recovery_us;
    } t_cfg;

    // one classified word as it waits for the sequencer
    typedef struct packed {
        logic [OFF_W-1:0]  offset;     // byte offset, low two bits cleared
        logic [OFF_W-1:0]  q_est;      // page number estimate, may be one low
        logic [OFF_W-1:0]  addr;       // converted flash address
        logic [DATA_W-1:0] data;
        logic              final_word;
    } t_word_desc;

endpackage

`default_nettype wire

// ----- rtl/fwps_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fwps_front
// Accepts words, converts the address and estimates the page number.
// ----------------------------------------------------------------------------
module fwps_front
    import fwps_pkg::*;
#(
    parameter int PAGE_BYTES = 128
) (
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [OFF_W-1:0] i_byte_offset,
    input  wire logic [DATA_W-1:0] i_word_data,
    input  wire logic             i_final_word,
    input  wire logic             i_nvr,
    output logic                  o_push,
    output t_word_desc            o_push_desc,
    input  wire logic             i_q_full
);

    localparam int            PROD_W = OFF_W + DATA_W;
    // floor(2^32 / PAGE_BYTES); the estimate is the page number or one less
    localparam logic [DATA_W-1:0] RECIP = DATA_W'((64'd1 << DATA_W) / PAGE_BYTES);

    logic [OFF_W-1:0]  off;
    logic [OFF_W-1:0]  addr;
    logic [PROD_W-1:0] prod;

    always_comb begin
        off  = {i_byte_offset[OFF_W-1:2], 2'b00};
        addr = {1'b0, off[OFF_W-1:3], 2'b00};
        if (off[2]) begin
            if (i_nvr) begin
                addr[ADDR_HI_NVR_POS] = 1'b1;
            end else begin
                addr[ADDR_HI_MAIN_POS] = 1'b1;
            end
        end
        prod = PROD_W'(off) * PROD_W'(RECIP);
    end

    assign o_in_stall             = i_q_full;
    assign o_push                 = i_in_valid & ~i_q_full;
    assign o_push_desc.offset     = off;
    assign o_push_desc.q_est      = prod[PROD_W-1:DATA_W];
    assign o_push_desc.addr       = addr;
    assign o_push_desc.data       = i_word_data;
    assign o_push_desc.final_word = i_final_word;

endmodule

`default_nettype wire

// ----- rtl/fwps_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fwps_queue
// Two-entry word queue between the front and the sequencer.
// ----------------------------------------------------------------------------
module fwps_queue
    import fwps_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_word_desc i_push_desc,
    output logic            o_full,
    input  wire logic       i_pop,
    output logic            o_valid,
    output t_word_desc      o_head
);

    t_word_desc r_ent0;
    t_word_desc r_ent1;
    logic [1:0] r_count;
    logic [1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // head always sits in entry 0
    always_ff @(posedge i_clk) begin
        if (i_push && i_pop) begin
            if (r_count == 2'd1) begin
                r_ent0 <= i_push_desc;
            end else begin
                r_ent0 <= r_ent1;
                r_ent1 <= i_push_desc;
            end
        end else if (i_push) begin
            if (r_count == 2'd0) begin
                r_ent0 <= i_push_desc;
            end else begin
                r_ent1 <= i_push_desc;
            end
        end else if (i_pop) begin
            r_ent0 <= r_ent1;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_ent0;

endmodule

`default_nettype wire

// ----- rtl/fwps_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fwps_back
// Action sequencer: walks page open, word program and page close steps,
// one flash register action per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module fwps_back
    import fwps_pkg::*;
#(
    parameter int PAGE_BYTES = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_q_valid,
    input  wire t_word_desc        i_q_head,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [1:0]             o_target_register,
    output logic [DATA_W-1:0]      o_register_value,
    output logic [WAIT_W-1:0]      o_wait_after_us,
    output logic                   o_last_action
);

    // remainder before correction stays below twice the page size
    localparam int RW = $clog2(PAGE_BYTES) + 1;

    typedef enum logic [10:0] {
        S_IDLE      = 11'h001,
        S_OPEN_ADDR = 11'h002,
        S_OPEN_RUN  = 11'h004,
        S_OPEN_WE   = 11'h008,
        S_ADDR      = 11'h010,
        S_DATA      = 11'h020,
        S_LANE_SEL  = 11'h040,
        S_PULSE     = 11'h080,
        S_DROP      = 11'h100,
        S_CLOSE_RUN = 11'h200,
        S_CLOSE_CMD = 11'h400
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [1:0]        r_lane;
    logic [1:0]        n_lane;
    logic              r_page_open;
    logic              n_page_open;
    t_word_desc        r_desc;
    logic [RW-1:0]     r_rem;
    logic [OFF_W-1:0]  rem_full;

    logic              r_out_valid;
    logic [1:0]        r_tgt;
    logic [DATA_W-1:0] r_val;
    logic [WAIT_W-1:0] r_wait;
    logic              r_last;

    logic              fire;
    logic              load;
    logic              open_eff;
    logic              close_hit;
    logic [RW:0]       rem_fix;
    logic [DATA_W-1:0] run;
    logic [DATA_W-1:0] runwe;
    logic [1:0]        act_tgt;
    logic [DATA_W-1:0] act_val;
    logic [WAIT_W-1:0] act_wait;
    logic              act_last;

    assign run   = i_cfg.base_command | BIT_CE | BIT_PROG;
    assign runwe = run | BIT_WE;

    always_comb begin
        rem_fix = (r_rem >= RW'(PAGE_BYTES)) ? {1'b0, r_rem - RW'(PAGE_BYTES)}
                                             : {1'b0, r_rem};
        close_hit = r_desc.final_word
                  | ((rem_fix + (RW+1)'(4)) >= (RW+1)'(PAGE_BYTES));
    end

    // action for the current step
    always_comb begin
        act_tgt  = TGT_CMD;
        act_val  = runwe;
        act_wait = '0;
        act_last = 1'b0;
        case (r_state)
            S_OPEN_ADDR: begin
                act_tgt = TGT_ADDR;
                act_val = DATA_W'(r_desc.addr);
            end
            S_OPEN_RUN: begin
                act_val  = run;
                act_wait = WAIT_W'(i_cfg.setup_wait_us);
            end
            S_OPEN_WE: begin
                act_wait = WAIT_W'(i_cfg.program_setup_us);
            end
            S_ADDR: begin
                act_tgt = TGT_ADDR;
                act_val = DATA_W'(r_desc.addr);
            end
            S_DATA: begin
                act_tgt = TGT_DIN;
                act_val = r_desc.data;
            end
            S_LANE_SEL: begin
                act_tgt  = TGT_CTRL;
                act_val  = DATA_W'(1) << r_lane;
                act_wait = WAIT_W'(i_cfg.address_setup_us);
            end
            S_PULSE: begin
                act_val  = runwe | BIT_PROG2;
                act_wait = WAIT_W'(i_cfg.program_pulse_us);
            end
            S_DROP: begin
                if (r_lane == 2'd3) begin
                    act_wait = WAIT_W'(i_cfg.address_hold_us)
                             + WAIT_W'(i_cfg.program_hold_us);
                    act_last = ~close_hit;
                end else begin
                    act_wait = WAIT_W'(i_cfg.address_hold_us);
                end
            end
            S_CLOSE_RUN: begin
                act_val  = run;
                act_wait = WAIT_W'(i_cfg.recovery_us);
            end
            S_CLOSE_CMD: begin
                act_val  = i_cfg.base_command;
                act_wait = CLOSE_HOLD_US;
                act_last = 1'b1;
            end
            default: begin
                act_tgt = TGT_CMD;
            end
        endcase
    end

    assign fire = (r_state != S_IDLE) && (!r_out_valid || !i_out_stall);
    // next word starts straight after the last action of the previous one
    assign load = i_q_valid && ((r_state == S_IDLE) || (fire && act_last));
    // a page that closes in this cycle is not open for the next word
    assign open_eff = r_page_open && !(fire && (r_state == S_CLOSE_CMD));

    always_comb begin
        n_state     = r_state;
        n_lane      = r_lane;
        n_page_open = open_eff;
        if (fire) begin
            case (r_state)
                S_OPEN_ADDR: n_state = S_OPEN_RUN;
                S_OPEN_RUN:  n_state = S_OPEN_WE;
                S_OPEN_WE:   n_state = S_ADDR;
                S_ADDR:      n_state = S_DATA;
                S_DATA:      n_state = S_LANE_SEL;
                S_LANE_SEL:  n_state = S_PULSE;
                S_PULSE:     n_state = S_DROP;
                S_DROP: begin
                    if (r_lane != 2'd3) begin
                        n_state = S_LANE_SEL;
                        n_lane  = r_lane + 2'd1;
                    end else if (close_hit) begin
                        n_state = S_CLOSE_RUN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
                S_CLOSE_RUN: n_state = S_CLOSE_CMD;
                S_CLOSE_CMD: n_state = S_IDLE;
                default:     n_state = S_IDLE;
            endcase
        end
        if (load) begin
            n_state     = open_eff ? S_ADDR : S_OPEN_ADDR;
            n_lane      = 2'd0;
            n_page_open = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lane      <= 2'd0;
            r_page_open <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lane      <= n_lane;
            r_page_open <= n_page_open;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // offset minus estimated page start
    assign rem_full = i_q_head.offset
                    - OFF_W'(DATA_W'(i_q_head.q_est) * DATA_W'(PAGE_BYTES));

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_desc <= i_q_head;
            r_rem  <= rem_full[RW-1:0];
        end
        if (fire) begin
            r_tgt  <= act_tgt;
            r_val  <= act_val;
            r_wait <= act_wait;
            r_last <= act_last;
        end
    end

    assign o_pop             = load;
    assign o_out_valid       = r_out_valid;
    assign o_target_register = r_tgt;
    assign o_register_value  = r_val;
    assign o_wait_after_us   = r_wait;
    assign o_last_action     = r_last;

endmodule

`default_nettype wire

// ----- rtl/flash_word_program_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// flash_word_program_sequencer
// Turns words to program into timed flash register actions.
// ----------------------------------------------------------------------------
// Each accepted word yields 14 register actions, 17 when a page has to be
// opened first and 2 more when the page closes, so 14 to 19 actions per word.
// The sequencer emits one action per clock into the output register while
// the output is not stalled, and the next queued word follows straight
// after the last action of the previous one. A two-word queue sits in
// front of the sequencer; input words are taken while it has room.
// Configuration writes are expected only while no word is in flight.
module flash_word_program_sequencer
    import fwps_pkg::*;
#(
    parameter int PAGE_BYTES = 128
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0]    i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [OFF_W-1:0]     i_byte_offset,
    input  wire logic [DATA_W-1:0]    i_word_data,
    input  wire logic                 i_final_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_target_register,
    output logic [DATA_W-1:0]         o_register_value,
    output logic [WAIT_W-1:0]         o_wait_after_us,
    output logic                      o_last_action
);

    t_cfg       r_cfg;
    logic       push;
    t_word_desc push_desc;
    logic       q_full;
    logic       q_valid;
    t_word_desc q_head;
    logic       pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_command     <= RST_BASE_COMMAND;
            r_cfg.setup_wait_us    <= RST_SETUP_WAIT_US;
            r_cfg.program_setup_us <= RST_PROGRAM_SETUP_US;
            r_cfg.address_setup_us <= RST_ADDRESS_SETUP_US;
            r_cfg.program_pulse_us <= RST_PROGRAM_PULSE_US;
            r_cfg.address_hold_us  <= RST_ADDRESS_HOLD_US;
            r_cfg.program_hold_us  <= RST_PROGRAM_HOLD_US;
            r_cfg.recovery_us      <= RST_RECOVERY_US;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_COMMAND:     r_cfg.base_command     <= i_cfg_data;
                CFG_SETUP_WAIT_US:    r_cfg.setup_wait_us    <= i_cfg_data[HOLD_W-1:0];
                CFG_PROGRAM_SETUP_US: r_cfg.program_setup_us <= i_cfg_data[HOLD_W-1:0];
                CFG_ADDRESS_SETUP_US: r_cfg.address_setup_us <= i_cfg_data[HOLD_W-1:0];
                CFG_PROGRAM_PULSE_US: r_cfg.program_pulse_us <= i_cfg_data[HOLD_W-1:0];
                CFG_ADDRESS_HOLD_US:  r_cfg.address_hold_us  <= i_cfg_data[HOLD_W-1:0];
                CFG_PROGRAM_HOLD_US:  r_cfg.program_hold_us  <= i_cfg_data[HOLD_W-1:0];
                CFG_RECOVERY_US:      r_cfg.recovery_us      <= i_cfg_data[HOLD_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    fwps_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_byte_offset (i_byte_offset),
        .i_word_data   (i_word_data),
        .i_final_word  (i_final_word),
        .i_nvr         (r_cfg.base_command[NVR_POS]),
        .o_push        (push),
        .o_push_desc   (push_desc),
        .i_q_full      (q_full)
    );

    fwps_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_desc (push_desc),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_head      (q_head)
    );

    fwps_back #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_q_valid         (q_valid),
        .i_q_head          (q_head),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_target_register (o_target_register),
        .o_register_value  (o_register_value),
        .o_wait_after_us   (o_wait_after_us),
        .o_last_action     (o_last_action)
    );

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Flash word program sequencer testbench
// Sends words to program through the input channel and predicts the timed
// register actions that each word causes: page open, address and data
// writes, four byte lanes with their PROG2 pulse, and page close. Every
// action leaving the block is checked against the predicted one, field by
// field, under random idling on both channels, a long output hold-off,
// and a range of configuration settings.
// ----------------------------------------------------------------------------
module testbench
    import fwps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE_BYTES     = 128;
    localparam int HOLDOFF_CYCLES = 250;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int MAX_REPORTS    = 60;

    typedef struct packed {
        logic [1:0]        target;
        logic [DATA_W-1:0] value;
        logic [WAIT_W-1:0] hold_us;
        logic              last;
    } t_flash_action;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [DATA_W-1:0]    i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic [OFF_W-1:0]     i_byte_offset = '0;
    logic [DATA_W-1:0]    i_word_data   = '0;
    logic                 i_final_word  = 1'b0;
    logic                 i_out_stall   = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [1:0]           o_target_register;
    logic [DATA_W-1:0]    o_register_value;
    logic [WAIT_W-1:0]    o_wait_after_us;
    logic                 o_last_action;

    // predictor state
    t_flash_action expected_actions[$];
    t_cfg          model_cfg;
    logic          page_is_open;

    int mismatch_count   = 0;
    int cycle_count      = 0;
    int tx_idle_pct      = 0;
    int rx_idle_pct      = 0;
    int holdoff_requests = 0;

    flash_word_program_sequencer #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_byte_offset    (i_byte_offset),
        .i_word_data      (i_word_data),
        .i_final_word     (i_final_word),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_target_register(o_target_register),
        .o_register_value (o_register_value),
        .o_wait_after_us  (o_wait_after_us),
        .o_last_action    (o_last_action)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void push_action(input logic [1:0] target,
                                        input logic [DATA_W-1:0] value,
                                        input logic [WAIT_W-1:0] hold_us,
                                        input logic last);
        t_flash_action act;
        act.target  = target;
        act.value   = value;
        act.hold_us = hold_us;
        act.last    = last;
        expected_actions.push_back(act);
    endfunction

    function automatic void predict_word(input logic [OFF_W-1:0] raw_off,
                                         input logic [DATA_W-1:0] data,
                                         input logic fin);
        logic [OFF_W-1:0]  off;
        logic [DATA_W-1:0] flash_addr;
        logic [DATA_W-1:0] run_cmd;
        logic [DATA_W-1:0] run_we;
        logic [WAIT_W-1:0] lane_hold;
        logic              closing;
        off        = {raw_off[OFF_W-1:2], 2'b00};
        flash_addr = DATA_W'(off >> 1) & ~32'd3;
        // odd word: high address bit depends on main block vs. info block
        if (off[2]) begin
            if (model_cfg.base_command[NVR_POS])
                flash_addr[ADDR_HI_NVR_POS] = 1'b1;
            else
                flash_addr[ADDR_HI_MAIN_POS] = 1'b1;
        end
        closing = fin || ((int'(off) % PAGE_BYTES) + 4 >= PAGE_BYTES);
        run_cmd = model_cfg.base_command | BIT_CE | BIT_PROG;
        run_we  = run_cmd | BIT_WE;

        if (!page_is_open) begin
            push_action(TGT_ADDR, flash_addr, '0, 1'b0);
            push_action(TGT_CMD, run_cmd, WAIT_W'(model_cfg.setup_wait_us), 1'b0);
            push_action(TGT_CMD, run_we, WAIT_W'(model_cfg.program_setup_us), 1'b0);
            page_is_open = 1'b1;
        end

        push_action(TGT_ADDR, flash_addr, '0, 1'b0);
        push_action(TGT_DIN, data, '0, 1'b0);
        for (int lane = 0; lane < 4; lane++) begin
            lane_hold = WAIT_W'(model_cfg.address_hold_us);
            if (lane == 3)
                lane_hold = lane_hold + WAIT_W'(model_cfg.program_hold_us);
            push_action(TGT_CTRL, 32'd1 << lane, WAIT_W'(model_cfg.address_setup_us), 1'b0);
            push_action(TGT_CMD, run_we | BIT_PROG2, WAIT_W'(model_cfg.program_pulse_us), 1'b0);
            push_action(TGT_CMD, run_we, lane_hold, lane == 3 && !closing);
        end

        if (closing) begin
            push_action(TGT_CMD, run_cmd, WAIT_W'(model_cfg.recovery_us), 1'b0);
            push_action(TGT_CMD, model_cfg.base_command, CLOSE_HOLD_US, 1'b1);
            page_is_open = 1'b0;
        end
    endfunction

    function automatic void compare_field(input string name,
                                          input logic [DATA_W-1:0] want,
                                          input logic [DATA_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // monitor: config tracking, prediction on accepted words, action check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : action_checker
        t_flash_action want;
        if (!i_rst_n) begin
            model_cfg.base_command     = RST_BASE_COMMAND;
            model_cfg.setup_wait_us    = RST_SETUP_WAIT_US;
            model_cfg.program_setup_us = RST_PROGRAM_SETUP_US;
            model_cfg.address_setup_us = RST_ADDRESS_SETUP_US;
            model_cfg.program_pulse_us = RST_PROGRAM_PULSE_US;
            model_cfg.address_hold_us  = RST_ADDRESS_HOLD_US;
            model_cfg.program_hold_us  = RST_PROGRAM_HOLD_US;
            model_cfg.recovery_us      = RST_RECOVERY_US;
            page_is_open = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_actions.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected action, expected none, actual %0h %0h %0h %0h",
                                 $realtime, o_target_register, o_register_value,
                                 o_wait_after_us, o_last_action);
                end else begin
                    want = expected_actions.pop_front();
                    compare_field("target_register", DATA_W'(want.target),
                                  DATA_W'(o_target_register));
                    compare_field("register_value", want.value, o_register_value);
                    compare_field("wait_after_us", DATA_W'(want.hold_us),
                                  DATA_W'(o_wait_after_us));
                    compare_field("last_action", DATA_W'(want.last), DATA_W'(o_last_action));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE_COMMAND:     model_cfg.base_command     = i_cfg_data;
                    CFG_SETUP_WAIT_US:    model_cfg.setup_wait_us    = i_cfg_data[HOLD_W-1:0];
                    CFG_PROGRAM_SETUP_US: model_cfg.program_setup_us = i_cfg_data[HOLD_W-1:0];
                    CFG_ADDRESS_SETUP_US: model_cfg.address_setup_us = i_cfg_data[HOLD_W-1:0];
                    CFG_PROGRAM_PULSE_US: model_cfg.program_pulse_us = i_cfg_data[HOLD_W-1:0];
                    CFG_ADDRESS_HOLD_US:  model_cfg.address_hold_us  = i_cfg_data[HOLD_W-1:0];
                    CFG_PROGRAM_HOLD_US:  model_cfg.program_hold_us  = i_cfg_data[HOLD_W-1:0];
                    CFG_RECOVERY_US:      model_cfg.recovery_us      = i_cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall)
                predict_word(i_byte_offset, i_word_data, i_final_word);
        end
    end

    // output side: random stall, or a long hold-off when one is requested
    initial begin : out_stall_drive
        int hold_left;
        int seen_requests;
        hold_left     = 0;
        seen_requests = 0;
        forever begin
            @(posedge i_clk);
            if (holdoff_requests != seen_requests) begin
                seen_requests = holdoff_requests;
                hold_left     = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // valid stays high on return; end_burst drops it in the same step
    task automatic program_word(input logic [OFF_W-1:0] off, input logic [DATA_W-1:0] data,
                                input logic fin);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_byte_offset <= off;
        i_word_data   <= data;
        i_final_word  <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        do @(posedge i_clk); while (expected_actions.size() != 0);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all_holds(input logic [DATA_W-1:0] value);
        write_cfg(CFG_SETUP_WAIT_US, value);
        write_cfg(CFG_PROGRAM_SETUP_US, value);
        write_cfg(CFG_ADDRESS_SETUP_US, value);
        write_cfg(CFG_PROGRAM_PULSE_US, value);
        write_cfg(CFG_ADDRESS_HOLD_US, value);
        write_cfg(CFG_PROGRAM_HOLD_US, value);
        write_cfg(CFG_RECOVERY_US, value);
    endtask

    // upper data bits are random too; hold registers must drop them
    task automatic randomize_config();
        write_cfg(CFG_BASE_COMMAND, $urandom);
        write_cfg(CFG_SETUP_WAIT_US, $urandom);
        write_cfg(CFG_PROGRAM_SETUP_US, $urandom);
        write_cfg(CFG_ADDRESS_SETUP_US, $urandom);
        write_cfg(CFG_PROGRAM_PULSE_US, $urandom);
        write_cfg(CFG_ADDRESS_HOLD_US, $urandom);
        write_cfg(CFG_PROGRAM_HOLD_US, $urandom);
        write_cfg(CFG_RECOVERY_US, $urandom);
    endtask

    // mostly runs of consecutive words in one page, some noise words
    task automatic send_random_words(input int n_words);
        int               sent;
        int               slot;
        int               run_len;
        logic [OFF_W-1:0] page_base;
        logic [OFF_W-1:0] off;
        logic             fin;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 99) < 80) begin
                page_base = OFF_W'($urandom);
                page_base = page_base - OFF_W'(page_base % PAGE_BYTES);
                slot      = $urandom_range(0, PAGE_BYTES / 4 - 1);
                run_len   = $urandom_range(1, PAGE_BYTES / 4 - slot);
                if (run_len > 8 && $urandom_range(0, 3) != 0)
                    run_len = $urandom_range(1, 8);
                if (run_len > n_words - sent)
                    run_len = n_words - sent;
                for (int k = 0; k < run_len; k++) begin
                    off = page_base + OFF_W'((slot + k) * 4) + OFF_W'($urandom_range(0, 3));
                    // sometimes the run leaves the page open for the next one
                    fin = (k == run_len - 1) && ($urandom_range(0, 3) != 0);
                    program_word(off, $urandom, fin);
                end
                sent += run_len;
            end else begin
                program_word(OFF_W'($urandom), $urandom, 1'($urandom_range(0, 1)));
                sent++;
            end
        end
        end_burst();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_page_handling();
        program_word(19'h00000, 32'h0000_0000, 1'b1);
        // odd word opens a page and leaves it open
        program_word(19'h00004, 32'hFFFF_FFFF, 1'b0);
        // word from another page while open: no reopen, low bits ignored
        program_word(19'h0010B, 32'hA5A5_5A5A, 1'b0);
        // last slot of a page closes it
        program_word(19'h0007C, 32'h1234_5678, 1'b0);
        program_word(19'h7FFFF, 32'h8000_0001, 1'b0);
        program_word(19'h00200, 32'h0F0F_F0F0, 1'b0);
        program_word(19'h00206, 32'hDEAD_BEEF, 1'b0);
        program_word(19'h00209, 32'h0000_0001, 1'b1);
        end_burst();
        wait_drain();
        // information block: odd words take the other high address bit
        write_cfg(CFG_BASE_COMMAND, 32'd1 << NVR_POS);
        program_word(19'h00004, 32'h5555_AAAA, 1'b0);
        program_word(19'h0000C, 32'hAAAA_5555, 1'b1);
        program_word(19'h3FFF4, 32'h7FFF_FFFF, 1'b1);
        end_burst();
        wait_drain();
    endtask

    task automatic test_register_extremes();
        write_cfg(CFG_BASE_COMMAND, 32'hFFFF_FFFF);
        write_all_holds(32'hFFFF_FFFF);
        program_word(19'h00040, 32'hC3C3_3C3C, 1'b0);
        program_word(19'h00044, 32'h3C3C_C3C3, 1'b1);
        program_word(19'h4007C, 32'hFFFF_0000, 1'b0);
        end_burst();
        wait_drain();
        write_cfg(CFG_BASE_COMMAND, 32'd0);
        write_all_holds(32'd0);
        program_word(19'h01004, 32'h0000_FFFF, 1'b1);
        program_word(19'h7FF7C, 32'h0102_0304, 1'b0);
        end_burst();
        wait_drain();
    endtask

    task automatic test_back_pressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        randomize_config();
        // output held off while words keep coming: input must stall
        holdoff_requests++;
        send_random_words(12);
        wait_drain();
        // sender resumes only after everything has drained
        send_random_words(6);
        wait_drain();
    endtask

    task automatic test_random_traffic();
        tx_idle_pct = 31;
        rx_idle_pct = 59;
        randomize_config();
        send_random_words(50);
        wait_drain();
        tx_idle_pct = 59;
        rx_idle_pct = 31;
        randomize_config();
        send_random_words(50);
        wait_drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        randomize_config();
        send_random_words(50);
        wait_drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_page_handling();
        test_register_extremes();
        test_back_pressure();
        test_random_traffic();
        wait_drain();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && expected_actions.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
